@@ rtl/deq_pkg.sv @@
// Shared types, constants and slot arithmetic for the double-ended queue.
package deq_pkg;

	localparam int DEPTH       = 16;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int SUM_W       = CNT_W + 1;
	localparam int WORD_W      = 32;
	localparam int REQ_W       = 3;
	localparam int COUNT_OUT_W = 5;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_BACK   = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_READ       = 3'd4
	} req_code_t;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [WORD_W-1:0] push_value;
	} deq_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [COUNT_OUT_W-1:0]   element_count;
		logic                     empty_error;
		logic                     overflow;
	} deq_rsp_t;

	// Memory access and status for one accepted request.
	typedef struct packed {
		logic                     wr_en;
		logic [ADDR_W-1:0]        wr_addr;
		logic signed [WORD_W-1:0] wr_data;
		logic [ADDR_W-1:0]        front_addr;
		logic [ADDR_W-1:0]        back_addr;
		logic [CNT_W-1:0]         count;
		logic                     empty_error;
		logic                     overflow;
	} deq_ctl_t;

	// Ring slot base + offset, offset at most DEPTH.
	function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
		input logic [CNT_W-1:0] offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return ADDR_W'(sum);
	endfunction

	function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] base);
		logic [ADDR_W-1:0] prev;
		if (base == '0) begin
			prev = ADDR_W'(DEPTH - 1);
		end else begin
			prev = base - ADDR_W'(1);
		end
		return prev;
	endfunction

endpackage

@@ rtl/deq_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0]         rd_addr_b,
	output logic [WIDTH-1:0]                 rd_data_a,
	output logic [WIDTH-1:0]                 rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_a_q;
	logic [WIDTH-1:0] rd_data_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a_q <= mem_q[rd_addr_a];
		rd_data_b_q <= mem_q[rd_addr_b];
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

@@ rtl/deq_ctrl.sv @@
// Pointer and count state of the ring, and the memory access for each request.
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  deq_pkg::deq_req_t req,
	output deq_pkg::deq_ctl_t ctl
);

	logic [deq_pkg::ADDR_W-1:0] first_q;
	logic [deq_pkg::CNT_W-1:0]  count_q;
	logic [deq_pkg::ADDR_W-1:0] first_nxt;
	logic [deq_pkg::CNT_W-1:0]  count_nxt;
	logic                       full;
	logic                       empty;

	assign full  = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		first_nxt       = first_q;
		count_nxt       = count_q;
		ctl.wr_en       = 1'b0;
		ctl.wr_addr     = deq_pkg::slot_add(first_q, count_q);
		ctl.wr_data     = req.push_value;
		ctl.empty_error = 1'b0;
		ctl.overflow    = 1'b0;
		case (req.req_type)
			deq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					ctl.overflow = 1'b1;
				end else begin
					ctl.wr_en = 1'b1;
					count_nxt = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					ctl.overflow = 1'b1;
				end else begin
					first_nxt   = deq_pkg::slot_before(first_q);
					ctl.wr_en   = 1'b1;
					ctl.wr_addr = first_nxt;
					count_nxt   = count_q + deq_pkg::CNT_W'(1);
				end
			end
			deq_pkg::REQ_POP_BACK, deq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					ctl.empty_error = 1'b1;
				end else begin
					if (req.req_type == deq_pkg::REQ_POP_FRONT) begin
						first_nxt = deq_pkg::slot_add(first_q, deq_pkg::CNT_W'(1));
					end
					count_nxt = count_q - deq_pkg::CNT_W'(1);
					if (count_nxt == '0) begin
						first_nxt = '0;
					end
				end
			end
			default: begin
			end
		endcase
		ctl.count      = count_nxt;
		ctl.front_addr = first_nxt;
		ctl.back_addr  = deq_pkg::slot_add(first_nxt,
			(count_nxt == '0) ? '0 : count_nxt - deq_pkg::CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			first_q <= first_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

@@ rtl/double_ended_queue_core.sv @@
// Bounded double-ended queue of signed words in a ring held in one RAM.
// The result strobe (done) rises in the cycle after the request is accepted.
// Throughput: one request per cycle; busy stays low, since pointer state updates at accept.
// The RAM's read data is registered; a same-cycle write is forwarded.
// Reset (arst_n low, asynchronous) empties the deque and drops any pending result.
// Results are shown for exactly one cycle; the receiver cannot stall them.
module double_ended_queue_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  deq_pkg::deq_req_t req,
	output logic              done,
	output deq_pkg::deq_rsp_t rsp
);

	logic                             accept;
	deq_pkg::deq_ctl_t                ctl;
	logic [deq_pkg::WORD_W-1:0]       front_rd;
	logic [deq_pkg::WORD_W-1:0]       back_rd;

	// Result stage: status of the request whose RAM reads are in flight.
	logic                             done_s1;
	logic [deq_pkg::CNT_W-1:0]        count_s1;
	logic                             empty_error_s1;
	logic                             overflow_s1;
	logic                             fwd_front_s1;
	logic                             fwd_back_s1;
	logic signed [deq_pkg::WORD_W-1:0] wr_data_s1;

	// Every request completes in a single pass; no request is ever held off.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.ctl    (ctl)
	);

	// Write the pushed beat and read both ends at the new pointers in the same cycle.
	deq_ram #(
		.WIDTH (deq_pkg::WORD_W),
		.DEPTH (deq_pkg::DEPTH)
	) u_ram (
		.clk       (clk),
		.wr_en     (accept && ctl.wr_en),
		.wr_addr   (ctl.wr_addr),
		.wr_data   (ctl.wr_data),
		.rd_addr_a (ctl.front_addr),
		.rd_addr_b (ctl.back_addr),
		.rd_data_a (front_rd),
		.rd_data_b (back_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Payload of the result stage; capture only on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1       <= ctl.count;
			empty_error_s1 <= ctl.empty_error;
			overflow_s1    <= ctl.overflow;
			// The RAM returns old data when read and written at one address: forward.
			fwd_front_s1   <= ctl.wr_en && (ctl.wr_addr == ctl.front_addr);
			fwd_back_s1    <= ctl.wr_en && (ctl.wr_addr == ctl.back_addr);
			wr_data_s1     <= ctl.wr_data;
		end
	end

	always_comb begin
		rsp.element_count = deq_pkg::COUNT_OUT_W'(count_s1);
		rsp.empty_error   = empty_error_s1;
		rsp.overflow      = overflow_s1;
		if (count_s1 == '0) begin
			rsp.front_value = deq_pkg::EMPTY_WORD;
			rsp.back_value  = deq_pkg::EMPTY_WORD;
		end else begin
			rsp.front_value = fwd_front_s1 ? wr_data_s1 : $signed(front_rd);
			rsp.back_value  = fwd_back_s1 ? wr_data_s1 : $signed(back_rd);
		end
	end

	assign done = done_s1;

endmodule

@@ rtl/deq_checker.sv @@
// Port-level checks of the double-ended queue, bound to the top level.
module deq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input deq_pkg::deq_rsp_t rsp
);

	// One result beat per accepted request, in the next cycle.
	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result beat after accepted request");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result beat without request");

	// An empty deque reports all-ones at both ends.
	a_empty_reads_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.element_count == '0) |->
		(rsp.front_value == deq_pkg::EMPTY_WORD && rsp.back_value == deq_pkg::EMPTY_WORD))
		else $error("empty deque ends not all ones");

	// A single stored word is both front and back.
	a_single_word_ends_match: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.element_count == deq_pkg::COUNT_OUT_W'(1)) |->
		(rsp.front_value == rsp.back_value))
		else $error("front and back differ with one word stored");

	// A failed pop leaves an empty deque and never coincides with overflow.
	a_empty_error_state: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.empty_error) |->
		(rsp.element_count == '0 && !rsp.overflow))
		else $error("empty error with stored words or overflow");

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

@@ test/tb_double_ended_queue_core.sv @@
// Self-checking testbench for double_ended_queue_core: directed and random request beats.
`timescale 1ns / 100ps

module tb_double_ended_queue_core;
	import deq_pkg::*;

	// The block answers in the cycle after accept; SETTLE_CYCLES lets it settle.
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 1550;
	localparam int CYCLE_LIMIT   = 200000;
	// Accept-count window in which the driver never idles.
	localparam int QUIET_LO      = 700;
	localparam int QUIET_HI      = 1000;

	// Request mix of one random burst.
	typedef enum int {
		BIAS_FILL,
		BIAS_DRAIN,
		BIAS_MIX
	} burst_bias_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	deq_req_t req;
	logic     done;
	deq_rsp_t rsp;

	// Request beats waiting for the driver, and front/back views waiting for done.
	deq_req_t req_backlog[$];
	deq_rsp_t expected_views[$];

	// Shadow deque: ring slots, front slot and fill level at the block's widths.
	logic signed [WORD_W-1:0] shadow_slots [DEPTH];
	logic [ADDR_W-1:0]        shadow_head;
	logic [CNT_W-1:0]         shadow_fill;

	int mismatches;
	int accepted;
	int cycles;

	double_ended_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	// Apply one request to the shadow deque and return the view the block must report.
	function automatic deq_rsp_t deque_predict(input deq_req_t r);
		deq_rsp_t view;
		int       tail;
		view = '0;
		case (r.req_type)
			REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
				if (int'(shadow_fill) >= DEPTH) begin
					// Full: drop the word, flag it, keep state.
					view.overflow = 1'b1;
				end else if (r.req_type == REQ_PUSH_BACK) begin
					tail = (int'(shadow_head) + int'(shadow_fill)) % DEPTH;
					shadow_slots[tail] = r.push_value;
					shadow_fill = shadow_fill + 1'b1;
				end else begin
					// Front push steps the head back one slot, wrapping at zero.
					shadow_head = ADDR_W'((int'(shadow_head) + DEPTH - 1) % DEPTH);
					shadow_slots[shadow_head] = r.push_value;
					shadow_fill = shadow_fill + 1'b1;
				end
			end
			REQ_POP_BACK, REQ_POP_FRONT: begin
				if (shadow_fill == '0) begin
					view.empty_error = 1'b1;
				end else begin
					if (r.req_type == REQ_POP_FRONT) begin
						shadow_head = ADDR_W'((int'(shadow_head) + 1) % DEPTH);
					end
					shadow_fill = shadow_fill - 1'b1;
					// Drained: park the head back at slot zero.
					if (shadow_fill == '0) begin
						shadow_head = '0;
					end
				end
			end
			default: begin
				// Read only, and the unused codes act the same.
			end
		endcase
		if (shadow_fill == '0) begin
			view.front_value = EMPTY_WORD;
			view.back_value  = EMPTY_WORD;
		end else begin
			tail = (int'(shadow_head) + int'(shadow_fill) - 1) % DEPTH;
			view.front_value = shadow_slots[shadow_head];
			view.back_value  = shadow_slots[tail];
		end
		view.element_count = COUNT_OUT_W'(shadow_fill);
		return view;
	endfunction

	task automatic queue_request(input logic [REQ_W-1:0] code, input logic [WORD_W-1:0] value);
		deq_req_t r;
		r.req_type   = code;
		r.push_value = value;
		req_backlog = {req_backlog, r};
	endtask

	// Pick a word: mostly random, sometimes one of the corner values.
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		case ($urandom_range(15))
			0:       w = {1'b1, {(WORD_W-1){1'b0}}};
			1:       w = {1'b0, {(WORD_W-1){1'b1}}};
			2:       w = '0;
			3:       w = '1;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Build one random request under the burst's bias toward filling or draining.
	function automatic deq_req_t pick_request(input burst_bias_t bias);
		deq_req_t r;
		int       roll;
		int       push_top;
		int       pop_top;
		roll = $urandom_range(99);
		case (bias)
			BIAS_FILL:  begin push_top = 70; pop_top = 90; end
			BIAS_DRAIN: begin push_top = 20; pop_top = 90; end
			default:    begin push_top = 42; pop_top = 84; end
		endcase
		if (roll < push_top) begin
			r.req_type = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
		end else if (roll < pop_top) begin
			r.req_type = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
		end else begin
			// Read only or one of the unused codes above it.
			r.req_type = REQ_READ + REQ_W'($urandom_range(3));
		end
		r.push_value = pick_word();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
		input logic [WORD_W-1:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Driver: on accept, predict and drop the beat; then present the next or idle.
	always @(posedge clk) begin : drive
		logic idle;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_views = {expected_views, deque_predict(req)};
				req_backlog.delete(0);
				accepted++;
			end
			idle = (accepted < QUIET_LO || accepted >= QUIET_HI) && ($urandom_range(99) < 23);
			if (req_backlog.size() != 0 && !idle) begin
				start <= 1'b1;
				req   <= req_backlog[0];
			end else begin
				start <= 1'b0;
				req   <= {REQ_W'(REQ_READ), WORD_W'($urandom)};
			end
		end
	end

	// Monitor: every done beat must match the oldest expected view, field by field.
	always @(posedge clk) begin : watch
		deq_rsp_t want;
		if (arst_n && done) begin
			if (expected_views.size() == 0) begin
				report_mismatch("result with nothing expected", rsp.front_value, '0);
			end else begin
				want = expected_views[0];
				expected_views.delete(0);
				if (rsp.front_value !== want.front_value) begin
					report_mismatch("front_value", rsp.front_value, want.front_value);
				end
				if (rsp.back_value !== want.back_value) begin
					report_mismatch("back_value", rsp.back_value, want.back_value);
				end
				if (rsp.element_count !== want.element_count) begin
					report_mismatch("element_count", WORD_W'(rsp.element_count),
						WORD_W'(want.element_count));
				end
				if (rsp.empty_error !== want.empty_error) begin
					report_mismatch("empty_error", WORD_W'(rsp.empty_error),
						WORD_W'(want.empty_error));
				end
				if (rsp.overflow !== want.overflow) begin
					report_mismatch("overflow", WORD_W'(rsp.overflow), WORD_W'(want.overflow));
				end
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_double_ended_queue_core failed");
			$finish;
		end
	end

	initial begin : stimulus
		burst_bias_t bias;
		int          burst;
		int          queued;
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		shadow_head = '0;
		shadow_fill = '0;
		mismatches  = 0;
		accepted    = 0;
		cycles      = 0;

		// Empty deque: read and both pops, which must flag empty.
		queue_request(REQ_READ, pick_word());
		queue_request(REQ_POP_BACK, pick_word());
		queue_request(REQ_POP_FRONT, pick_word());
		// Front push into an empty deque is a single insert.
		queue_request(REQ_PUSH_FRONT, 32'h1234_5678);
		queue_request(REQ_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}});
		queue_request(REQ_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}});
		// Unused codes behave as read only.
		queue_request(REQ_READ + 3'd1, pick_word());
		queue_request(REQ_READ + 3'd2, pick_word());
		queue_request(REQ_READ + 3'd3, pick_word());
		// Fill to the brim, a stored -1 among the words, then push past full at both ends.
		for (int i = 3; i < DEPTH; i++) begin
			queue_request((i % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, (i == 5) ? '1 : pick_word());
		end
		queue_request(REQ_PUSH_BACK, pick_word());
		queue_request(REQ_PUSH_FRONT, pick_word());
		queue_request(REQ_POP_BACK, pick_word());
		queue_request(REQ_POP_FRONT, pick_word());

		// Random bursts that swing the deque between empty and full.
		queued = 0;
		while (queued < RANDOM_ITEMS) begin
			bias  = burst_bias_t'($urandom_range(2));
			burst = $urandom_range(8, 40);
			for (int i = 0; i < burst; i++) begin
				req_backlog = {req_backlog, pick_request(bias)};
			end
			queued += burst;
		end

		// Hold reset, then release it on a clock edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Drain every beat and every expected view, then let the pipe settle.
		while (req_backlog.size() != 0 || expected_views.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_double_ended_queue_core passed");
		end else begin
			$display("tb_double_ended_queue_core failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_core.sv
rtl/deq_checker.sv
test/tb_double_ended_queue_core.sv
